@@ rtl/rkrw_pkg.sv @@
// Shared package for the key replay window checker.
// Holds sizing constants, request codes, controller types and pointer helpers.
// No dependencies.
`default_nettype none

package rkrw_pkg;

    // Ring sizing and key width.
    localparam int RING_DEPTH = 32;
    localparam int KEY_BITS   = 16;
    localparam int PTR_BITS   = $clog2(RING_DEPTH);
    localparam int SUM_BITS   = PTR_BITS + 1;
    localparam int LEN_BITS   = $clog2(RING_DEPTH + 1);

    // Fixed field widths of the ports and registers.
    localparam int KEY_FIELD_BITS = 16;
    localparam int WLEN_BITS      = 6;
    localparam int WSTEP_BITS     = 5;
    localparam int THRESH_BITS    = 4;
    localparam int APB_ADDR_BITS  = 4;
    localparam int APB_DATA_BITS  = 32;

    // Register indexes (word addresses on the configuration port).
    localparam logic [1:0] REG_WINDOW_LENGTH    = 2'd0;
    localparam logic [1:0] REG_WINDOW_STEP      = 2'd1;
    localparam logic [1:0] REG_REPEAT_THRESHOLD = 2'd2;

    // Request type codes.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CHECK  = 1'b1;

    // Register reset values.
    localparam logic [WLEN_BITS-1:0]   WLEN_RESET   = 6'd10;
    localparam logic [WSTEP_BITS-1:0]  WSTEP_RESET  = 5'd5;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_CMP_RD,
        ST_CMP_CHK,
        ST_FINISH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [WLEN_BITS-1:0]   window_length;
        logic [WSTEP_BITS-1:0]  window_step;
        logic [THRESH_BITS-1:0] repeat_threshold;
    } cfg_t;

    typedef struct packed {
        logic start_sample;
        logic arm_only;
        logic start_check;
        logic rd_probe;
        logic take_probe;
        logic next_i;
        logic rd_cmp;
        logic next_j;
        logic set_found;
        logic finish;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic armed;
        logic i_done;
        logic j_done;
        logic probe_zero;
        logic match;
        logic out_free;
    } status_t;

    // Sum of two ring pointers, wrapped once into the ring.
    function automatic logic [PTR_BITS-1:0] ptr_add(input logic [PTR_BITS-1:0] a,
                                                    input logic [PTR_BITS-1:0] b);
        logic [SUM_BITS-1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= SUM_BITS'(RING_DEPTH))
        begin
            s = s - SUM_BITS'(RING_DEPTH);
        end
        return PTR_BITS'(s);
    endfunction

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] a);
        return ptr_add(a, PTR_BITS'(1));
    endfunction

    // Window step reduced into the ring by repeated subtraction (narrow value).
    function automatic logic [PTR_BITS-1:0] step_wrap(input logic [WSTEP_BITS-1:0] s);
        logic [WSTEP_BITS-1:0] r;
        r = s;
        for (int k = 0; k < 8; k++)
        begin
            if (32'(r) >= RING_DEPTH)
            begin
                r = r - WSTEP_BITS'(RING_DEPTH);
            end
        end
        return PTR_BITS'(r);
    endfunction

endpackage

`default_nettype wire

@@ rtl/rkrw_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used for the key ring.
`default_nettype none

module rkrw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/rkrw_ctrl.sv @@
// Sequencer for the key replay window checker.
// Depends on rkrw_pkg; drives the datapath through cmd_t and reads status_t.
`default_nettype none

module rkrw_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    input  wire logic             req_type,
    output logic                  req_stall,
    input  wire rkrw_pkg::status_t sts,
    output rkrw_pkg::cmd_t        cmd
);

    rkrw_pkg::state_t state_reg;
    rkrw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rkrw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            rkrw_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    if (req_type == rkrw_pkg::REQ_SAMPLE)
                    begin
                        cmd.start_sample = 1'b1;
                        state_next       = rkrw_pkg::ST_DONE;
                    end
                    else if (!sts.armed)
                    begin
                        cmd.arm_only = 1'b1;
                        state_next   = rkrw_pkg::ST_DONE;
                    end
                    else
                    begin
                        cmd.start_check = 1'b1;
                        state_next      = rkrw_pkg::ST_PROBE_RD;
                    end
                end
            end
            rkrw_pkg::ST_PROBE_RD:
            begin
                if (sts.i_done)
                begin
                    state_next = rkrw_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.rd_probe = 1'b1;
                    state_next   = rkrw_pkg::ST_PROBE_CHK;
                end
            end
            rkrw_pkg::ST_PROBE_CHK:
            begin
                if (sts.probe_zero)
                begin
                    cmd.next_i = 1'b1;
                    state_next = rkrw_pkg::ST_PROBE_RD;
                end
                else
                begin
                    cmd.take_probe = 1'b1;
                    state_next     = rkrw_pkg::ST_CMP_RD;
                end
            end
            rkrw_pkg::ST_CMP_RD:
            begin
                if (sts.j_done)
                begin
                    cmd.next_i = 1'b1;
                    state_next = rkrw_pkg::ST_PROBE_RD;
                end
                else
                begin
                    cmd.rd_cmp = 1'b1;
                    state_next = rkrw_pkg::ST_CMP_CHK;
                end
            end
            rkrw_pkg::ST_CMP_CHK:
            begin
                if (sts.match)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = rkrw_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.next_j = 1'b1;
                    state_next = rkrw_pkg::ST_CMP_RD;
                end
            end
            rkrw_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = rkrw_pkg::ST_DONE;
            end
            rkrw_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = rkrw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rkrw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/rkrw_dp.sv @@
// Datapath of the key replay window checker: key ring, sample state,
// window scan registers and the output register. Depends on rkrw_pkg, rkrw_ram.
`default_nettype none

module rkrw_dp (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [rkrw_pkg::KEY_FIELD_BITS-1:0]   key_value,
    input  wire rkrw_pkg::cfg_t                        cfg,
    input  wire rkrw_pkg::cmd_t                        cmd,
    output rkrw_pkg::status_t                          sts,
    output logic                                       rsp_valid,
    input  wire logic                                  rsp_stall,
    output logic                                       jamming_detected,
    output logic                                       duplicate_found,
    output logic [rkrw_pkg::KEY_FIELD_BITS-1:0]        duplicate_key
);

    localparam int PB = rkrw_pkg::PTR_BITS;
    localparam int LB = rkrw_pkg::LEN_BITS;
    localparam int KB = rkrw_pkg::KEY_BITS;
    localparam int FB = rkrw_pkg::KEY_FIELD_BITS;
    localparam int TB = rkrw_pkg::THRESH_BITS;

    // Sample state.
    logic [PB-1:0] wp_reg;
    logic [KB-1:0] prev_reg;
    logic [TB-1:0] cnt_reg;

    // Scan state.
    logic [PB-1:0] ws_reg;
    logic          armed_reg;
    logic [LB-1:0] len_reg;
    logic [LB-1:0] i_reg;
    logic [LB-1:0] j_reg;
    logic [KB-1:0] probe_reg;

    // Pending result.
    logic          jam_reg;
    logic          found_reg;
    logic [FB-1:0] dupkey_reg;

    // Output register.
    logic          out_valid_reg;
    logic          out_jam_reg;
    logic          out_found_reg;
    logic [FB-1:0] out_key_reg;

    // Ring storage; valid bits stand in for the cleared reset contents.
    logic [rkrw_pkg::RING_DEPTH-1:0] valid_reg;
    logic                            valid_q_reg;
    logic [KB-1:0]                   ram_rdata;
    logic [KB-1:0]                   ring_rd;
    logic [PB-1:0]                   rd_addr;
    logic                            ram_re;

    logic [KB-1:0] key_k;
    logic          is_repeat;
    logic [TB-1:0] cnt_new;
    logic          jam_now;
    logic [KB-1:0] store_val;
    logic [LB-1:0] len_sat;
    logic          out_free;

    assign key_k     = KB'(key_value);
    assign is_repeat = (key_k == prev_reg) && (key_k != '0);
    assign cnt_new   = is_repeat ? cnt_reg + TB'(1) : '0;
    assign jam_now   = cnt_new >= cfg.repeat_threshold;
    assign store_val = is_repeat ? '0 : key_k;

    always_comb
    begin
        if (32'(cfg.window_length) > rkrw_pkg::RING_DEPTH)
        begin
            len_sat = LB'(rkrw_pkg::RING_DEPTH);
        end
        else
        begin
            len_sat = LB'(cfg.window_length);
        end
    end

    assign ram_re  = cmd.rd_probe || cmd.rd_cmp;
    assign rd_addr = rkrw_pkg::ptr_add(ws_reg, cmd.rd_probe ? PB'(i_reg) : PB'(j_reg));
    assign ring_rd = valid_q_reg ? ram_rdata : '0;

    rkrw_ram #(
        .WIDTH(KB),
        .DEPTH(rkrw_pkg::RING_DEPTH)
    ) u_ring (
        .clk  (clk),
        .we   (cmd.start_sample),
        .waddr(wp_reg),
        .wdata(store_val),
        .re   (ram_re),
        .raddr(rd_addr),
        .rdata(ram_rdata)
    );

    assign out_free = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        sts.armed      = armed_reg;
        sts.i_done     = i_reg >= len_reg;
        sts.j_done     = j_reg >= len_reg;
        sts.probe_zero = ring_rd == '0;
        sts.match      = ring_rd == probe_reg;
        sts.out_free   = out_free;
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            prev_reg      <= '0;
            cnt_reg       <= '0;
            ws_reg        <= '0;
            armed_reg     <= 1'b0;
            valid_reg     <= '0;
            found_reg     <= 1'b0;
            dupkey_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start_sample)
            begin
                wp_reg            <= rkrw_pkg::ptr_inc(wp_reg);
                prev_reg          <= key_k;
                cnt_reg           <= jam_now ? '0 : cnt_new;
                valid_reg[wp_reg] <= 1'b1;
            end
            if (cmd.arm_only)
            begin
                armed_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                ws_reg <= rkrw_pkg::ptr_add(ws_reg,
                                            rkrw_pkg::step_wrap(cfg.window_step));
            end
            if (cmd.start_sample || cmd.arm_only || cmd.start_check)
            begin
                found_reg  <= 1'b0;
                dupkey_reg <= '0;
            end
            else if (cmd.set_found)
            begin
                found_reg  <= 1'b1;
                dupkey_reg <= FB'(probe_reg);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            valid_q_reg <= valid_reg[rd_addr];
        end
        if (cmd.start_sample)
        begin
            jam_reg <= jam_now;
        end
        else if (cmd.arm_only || cmd.start_check)
        begin
            jam_reg <= 1'b0;
        end
        if (cmd.start_check)
        begin
            len_reg <= len_sat;
            i_reg   <= '0;
        end
        else if (cmd.next_i)
        begin
            i_reg <= i_reg + LB'(1);
        end
        if (cmd.take_probe)
        begin
            probe_reg <= ring_rd;
            j_reg     <= i_reg + LB'(1);
        end
        else if (cmd.next_j)
        begin
            j_reg <= j_reg + LB'(1);
        end
        if (cmd.load_out)
        begin
            out_jam_reg   <= jam_reg;
            out_found_reg <= found_reg;
            out_key_reg   <= dupkey_reg;
        end
    end

    assign rsp_valid        = out_valid_reg;
    assign jamming_detected = out_jam_reg;
    assign duplicate_found  = out_found_reg;
    assign duplicate_key    = out_key_reg;

    // A loaded result is offered in the next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("result load did not raise rsp_valid");

    // A reported duplicate always carries a nonzero key.
    a_found_key: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> dupkey_reg != '0)
        else $error("duplicate flagged with zero key");

    // A match is only taken against a nonzero probe.
    a_match_probe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_found |-> (probe_reg != '0) && (ring_rd == probe_reg))
        else $error("duplicate taken without a nonzero matching probe");

    // Each sample moves the write pointer by exactly one entry.
    a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_sample |=> wp_reg == rkrw_pkg::ptr_inc($past(wp_reg)))
        else $error("write pointer did not advance by one on a sample");

endmodule

`default_nettype wire

@@ rtl/rf_key_replay_window_checker.sv @@
// Top level of the key replay window checker: configuration registers on an
// APB-style port, the sequencer and the datapath. Depends on rkrw_pkg,
// rkrw_ctrl, rkrw_dp (and through it rkrw_ram).
//
//   Channel   Direction  Handshake             Beat contents
//   req       in         req_valid/req_stall   req_type, key_value
//   rsp       out        rsp_valid/rsp_stall   jamming_detected, duplicate_found,
//                                              duplicate_key
//   cfg       in         APB (psel/penable)    window_length, window_step,
//                                              repeat_threshold
//
// A key sample beat, and the first check beat after reset that only arms
// checking, goes from ST_IDLE to ST_DONE and is loaded into the output register
// once that register is free; the next request beat is taken back in ST_IDLE.
// A check beat walks the window through the single read port of the ring,
// reading each entry in ST_PROBE_RD or ST_CMP_RD and checking it in ST_PROBE_CHK
// or ST_CMP_CHK, then passes through ST_FINISH and ST_DONE to the output register.
// It probes at most L entries, L being the saturated window length, and does
// at most L*(L-1)/2 compares.
// Reset is asynchronous and active low; the ring contents read as zero after
// reset through per-entry valid bits, so no clearing pass is needed.
// One beat is in work at a time; a finished result waits in the output register
// while the next request beat is accepted, and a stalled rsp holds the sequencer
// only when a second result is ready to be delivered.
`default_nettype none

module rf_key_replay_window_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Request channel.
    input  wire logic                                 req_valid,
    output logic                                      req_stall,
    input  wire logic                                 req_type,
    input  wire logic [rkrw_pkg::KEY_FIELD_BITS-1:0]  key_value,
    // Result channel.
    output logic                                      rsp_valid,
    input  wire logic                                 rsp_stall,
    output logic                                      jamming_detected,
    output logic                                      duplicate_found,
    output logic [rkrw_pkg::KEY_FIELD_BITS-1:0]       duplicate_key,
    // Configuration port.
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [rkrw_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [rkrw_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [rkrw_pkg::APB_DATA_BITS-1:0]        prdata,
    output logic                                      pready
);

    localparam int DB = rkrw_pkg::APB_DATA_BITS;

    logic [rkrw_pkg::WLEN_BITS-1:0]   window_length_reg;
    logic [rkrw_pkg::WSTEP_BITS-1:0]  window_step_reg;
    logic [rkrw_pkg::THRESH_BITS-1:0] repeat_threshold_reg;

    rkrw_pkg::cfg_t    cfg;
    rkrw_pkg::cmd_t    cmd;
    rkrw_pkg::status_t sts;

    logic       cfg_write;
    logic [1:0] reg_index;

    // The port never inserts wait states. Registers sit on word addresses, so
    // the index is the address with the byte offset dropped.
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg    <= rkrw_pkg::WLEN_RESET;
            window_step_reg      <= rkrw_pkg::WSTEP_RESET;
            repeat_threshold_reg <= rkrw_pkg::THRESH_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                rkrw_pkg::REG_WINDOW_LENGTH:
                begin
                    window_length_reg <= pwdata[rkrw_pkg::WLEN_BITS-1:0];
                end
                rkrw_pkg::REG_WINDOW_STEP:
                begin
                    window_step_reg <= pwdata[rkrw_pkg::WSTEP_BITS-1:0];
                end
                rkrw_pkg::REG_REPEAT_THRESHOLD:
                begin
                    repeat_threshold_reg <= pwdata[rkrw_pkg::THRESH_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Read data is returned zero-extended; unmapped addresses read as zero.
    always_comb
    begin
        case (reg_index)
            rkrw_pkg::REG_WINDOW_LENGTH:    prdata = DB'(window_length_reg);
            rkrw_pkg::REG_WINDOW_STEP:      prdata = DB'(window_step_reg);
            rkrw_pkg::REG_REPEAT_THRESHOLD: prdata = DB'(repeat_threshold_reg);
            default:                        prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.window_length    = window_length_reg;
        cfg.window_step      = window_step_reg;
        cfg.repeat_threshold = repeat_threshold_reg;
    end

    // The sequencer decides what each cycle does; the datapath holds all state
    // that the result depends on.
    rkrw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_type (req_type),
        .req_stall(req_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    rkrw_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .key_value       (key_value),
        .cfg             (cfg),
        .cmd             (cmd),
        .sts             (sts),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .jamming_detected(jamming_detected),
        .duplicate_found (duplicate_found),
        .duplicate_key   (duplicate_key)
    );

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the key replay window checker.
// Compares every result beat against a cycle-free predictor of the ring, the
// repeat counter and the window scan. Depends on rkrw_pkg and the RTL top level.
`default_nettype none

module tb_top;

    import rkrw_pkg::*;

    // Run control. The slowest beat is a full check of 32 distinct keys; even if
    // every beat were that slow, the cycle cap leaves a wide margin over any
    // correct run.
    localparam int RESET_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 10_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_COUNT   = 14;
    localparam int PHASE_BEATS   = 100;
    localparam int POOL_SIZE     = 6;

    // One result beat as the block reports it.
    typedef struct packed {
        logic                      jamming;
        logic                      dup_found;
        logic [KEY_FIELD_BITS-1:0] dup_key;
    } replay_verdict_t;

    // How the two channels hold back during a phase.
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idling_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_stall;
    logic                       req_type = REQ_SAMPLE;
    logic [KEY_FIELD_BITS-1:0]  key_value = '0;
    logic                       rsp_valid;
    logic                       rsp_stall = 1'b0;
    logic                       jamming_detected;
    logic                       duplicate_found;
    logic [KEY_FIELD_BITS-1:0]  duplicate_key;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0]   paddr = '0;
    logic [APB_DATA_BITS-1:0]   pwdata = '0;
    logic [APB_DATA_BITS-1:0]   prdata;
    logic                       pready;

    rf_key_replay_window_checker DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .req_type         (req_type),
        .key_value        (key_value),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .jamming_detected (jamming_detected),
        .duplicate_found  (duplicate_found),
        .duplicate_key    (duplicate_key),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Shadow copy of the block state, updated in acceptance order.
    logic [KEY_FIELD_BITS-1:0] shadow_ring [RING_DEPTH];
    logic [PTR_BITS-1:0]       shadow_wr_ptr;
    logic [PTR_BITS-1:0]       shadow_win_start;
    logic [KEY_FIELD_BITS-1:0] shadow_last_key;
    logic [3:0]                shadow_repeats;
    bit                        shadow_armed;
    cfg_t                      shadow_cfg;

    replay_verdict_t           expected_verdicts [$];
    int                        error_count = 0;
    int                        cycle_count = 0;
    int                        req_idle_pct = 0;
    int                        rsp_stall_pct = 0;

    // Stimulus helpers: a per-phase pool of keys makes window duplicates
    // likely, and the last sample key lets runs of repeats be built.
    logic [KEY_FIELD_BITS-1:0] key_pool [POOL_SIZE];
    logic [KEY_FIELD_BITS-1:0] last_sample_key = '0;

    // Free-running cycle count; hitting the cap means something hung.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results still expected",
                   cycle_count, expected_verdicts.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void clear_shadow();
        foreach (shadow_ring[k])
        begin
            shadow_ring[k] = '0;
        end
        shadow_wr_ptr    = '0;
        shadow_win_start = '0;
        shadow_last_key  = '0;
        shadow_repeats   = '0;
        shadow_armed     = 1'b0;
        shadow_cfg       = '{window_length: WLEN_RESET, window_step: WSTEP_RESET,
                             repeat_threshold: THRESH_RESET};
    endfunction

    // Work out the result of one accepted beat and advance the shadow state.
    // A sample writes the ring and tracks repeats; the first check only arms, and
    // later ones scan the window for the first nonzero key that recurs later in it.
    function automatic replay_verdict_t predict_verdict(input logic kind,
                                                        input logic [KEY_FIELD_BITS-1:0] key);
        replay_verdict_t           v;
        int                        span;
        logic [KEY_FIELD_BITS-1:0] probe;
        v = '0;
        if (kind == REQ_SAMPLE)
        begin
            if (key == shadow_last_key && key != '0)
            begin
                // A nonzero repeat is stored as an empty slot.
                shadow_repeats = shadow_repeats + 4'd1;
                shadow_ring[shadow_wr_ptr] = '0;
            end
            else
            begin
                shadow_ring[shadow_wr_ptr] = key;
                shadow_repeats = '0;
            end
            // A zero threshold flags every sample.
            if (shadow_repeats >= shadow_cfg.repeat_threshold)
            begin
                v.jamming = 1'b1;
                shadow_repeats = '0;
            end
            shadow_last_key = key;
            shadow_wr_ptr   = shadow_wr_ptr + 1'b1;
        end
        else if (!shadow_armed)
        begin
            // The first check after reset only arms checking.
            shadow_armed = 1'b1;
        end
        else
        begin
            // Lengths past the ring size saturate; below two nothing compares.
            span = (shadow_cfg.window_length > RING_DEPTH) ? RING_DEPTH
                                                           : int'(shadow_cfg.window_length);
            for (int i = 0; i < span && !v.dup_found; i++)
            begin
                probe = shadow_ring[PTR_BITS'(shadow_win_start + i)];
                if (probe != '0)
                begin
                    for (int j = i + 1; j < span && !v.dup_found; j++)
                    begin
                        if (shadow_ring[PTR_BITS'(shadow_win_start + j)] == probe)
                        begin
                            v.dup_found = 1'b1;
                            v.dup_key   = probe;
                        end
                    end
                end
            end
            // The start moves modulo the ring depth.
            shadow_win_start = shadow_win_start + shadow_cfg.window_step;
        end
        return v;
    endfunction

    // Result checker and receiver back-pressure. Outputs are sampled at the
    // edge before any register in the block updates, so a beat counts when
    // valid is high and stall is low right at the edge.
    always @(posedge clk)
    begin
        replay_verdict_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("unexpected result: jamming=%0d found=%0d key=%h",
                       jamming_detected, duplicate_found, duplicate_key);
                error_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (jamming_detected !== want.jamming)
                begin
                    $error("jamming_detected: expected %0d, actual %0d",
                           want.jamming, jamming_detected);
                    error_count++;
                end
                if (duplicate_found !== want.dup_found)
                begin
                    $error("duplicate_found: expected %0d, actual %0d",
                           want.dup_found, duplicate_found);
                    error_count++;
                end
                if (duplicate_key !== want.dup_key)
                begin
                    $error("duplicate_key: expected %h, actual %h",
                           want.dup_key, duplicate_key);
                    error_count++;
                end
            end
        end
        rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end

    function automatic void set_idling(input idling_t mode);
        case (mode)
            IDLE_NONE:     begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            IDLE_SENDER:   begin req_idle_pct = 79; rsp_stall_pct = 0;  end
            IDLE_RECEIVER: begin req_idle_pct = 0;  rsp_stall_pct = 79; end
            default:       begin req_idle_pct = 26; rsp_stall_pct = 26; end
        endcase
    endfunction

    // Offer one request beat and hold it until it is accepted. The valid
    // stays high into the next beat unless a random gap is drawn, so it is
    // never dropped and raised again within one time step.
    task automatic send_beat(input logic kind, input logic [KEY_FIELD_BITS-1:0] key);
        int gap;
        req_valid <= 1'b1;
        req_type  <= kind;
        key_value <= key;
        do @(posedge clk); while (req_stall);
        expected_verdicts.push_back(predict_verdict(kind, key));
        if (kind == REQ_SAMPLE)
        begin
            last_sample_key = key;
        end
        gap = 0;
        while ($urandom_range(99) < req_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every expected result beat has come back.
    task automatic drain_results();
        req_valid <= 1'b0;
        do @(posedge clk); while (expected_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One APB write: setup phase, access phase, then the bus is released so
    // consecutive writes never touch psel twice in one step.
    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_WINDOW_LENGTH:    shadow_cfg.window_length    = value[WLEN_BITS-1:0];
            REG_WINDOW_STEP:      shadow_cfg.window_step      = value[WSTEP_BITS-1:0];
            REG_REPEAT_THRESHOLD: shadow_cfg.repeat_threshold = value[THRESH_BITS-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Registers change only once the block has gone quiet.
    task automatic apply_config(input int wlen, input int wstep, input int thresh);
        drain_results();
        write_register(REG_WINDOW_LENGTH, wlen);
        write_register(REG_WINDOW_STEP, wstep);
        write_register(REG_REPEAT_THRESHOLD, thresh);
    endtask

    // The first check only arms; the second scans an all-empty ring.
    task automatic test_first_check_arms();
        send_beat(REQ_CHECK, 16'hFFFF);
        send_beat(REQ_CHECK, 16'h0000);
    endtask

    // Runs of the same key, with zero keys that never count as repeats, at the
    // reset threshold and then at a threshold of zero.
    task automatic test_repeat_jamming();
        repeat (5) send_beat(REQ_SAMPLE, 16'hFFFF);
        send_beat(REQ_SAMPLE, 16'h0000);
        send_beat(REQ_SAMPLE, 16'h0000);
        send_beat(REQ_SAMPLE, 16'h0001);
        apply_config(int'(WLEN_RESET), int'(WSTEP_RESET), 0);
        send_beat(REQ_SAMPLE, 16'h8000);
        send_beat(REQ_SAMPLE, 16'h8000);
    endtask

    // A planted duplicate in a full-ring window, then windows too short to
    // compare, a length past the ring size and the widest step.
    task automatic test_window_extremes();
        apply_config(32, 0, 1);
        send_beat(REQ_SAMPLE, 16'h1234);
        send_beat(REQ_SAMPLE, 16'hABCD);
        send_beat(REQ_SAMPLE, 16'h1234);
        send_beat(REQ_CHECK, 16'h5A5A);
        apply_config(0, 31, 1);
        send_beat(REQ_CHECK, 16'h0000);
        apply_config(1, 31, 1);
        send_beat(REQ_CHECK, 16'hFFFF);
        apply_config(63, 31, 15);
        send_beat(REQ_CHECK, 16'h0000);
    endtask

    // Random phases. Each picks a setting and an idling mode; most samples
    // come from repeat runs and a small key pool so that jamming and window
    // duplicates actually occur, with zero and fully random keys mixed in.
    task automatic test_random_traffic();
        int                        wlen;
        int                        wstep;
        int                        thresh;
        int                        repeat_pct;
        logic                      kind;
        logic [KEY_FIELD_BITS-1:0] key;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: begin wlen = 2;  wstep = 0;  thresh = 1;  end
                1: begin wlen = 32; wstep = 31; thresh = 15; end
                2: begin wlen = 63; wstep = 16; thresh = 0;  end
                3: begin wlen = 1;  wstep = 7;  thresh = 2;  end
                default:
                begin
                    case ($urandom_range(9))
                        0:       wlen = $urandom_range(1) ? 32 : $urandom_range(63, 33);
                        1:       wlen = $urandom_range(1);
                        default: wlen = $urandom_range(12, 2);
                    endcase
                    wstep  = $urandom_range(31);
                    thresh = $urandom_range(15);
                end
            endcase
            apply_config(wlen, wstep, thresh);
            set_idling(idling_t'(phase % 4));
            foreach (key_pool[k])
            begin
                key_pool[k] = KEY_FIELD_BITS'($urandom);
            end
            // High thresholds need long runs before jamming shows up.
            repeat_pct = (thresh >= 8) ? 92 : 35;
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                // In one phase the sender regularly waits for the block to
                // empty completely before the next beat.
                if (phase == 5 && n % 10 == 0)
                begin
                    req_valid <= 1'b0;
                    do @(posedge clk); while (expected_verdicts.size() != 0);
                end
                kind = ($urandom_range(99) < 20) ? REQ_CHECK : REQ_SAMPLE;
                if ($urandom_range(99) < repeat_pct)
                begin
                    key = last_sample_key;
                end
                else
                begin
                    case ($urandom_range(9))
                        0:       key = '0;
                        1, 2, 3: key = KEY_FIELD_BITS'($urandom);
                        default: key = key_pool[$urandom_range(POOL_SIZE - 1)];
                    endcase
                end
                send_beat(kind, key);
            end
        end
    endtask

    initial
    begin
        clear_shadow();
        set_idling(IDLE_NONE);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_check_arms();
        test_repeat_jamming();
        test_window_extremes();
        test_random_traffic();

        drain_results();
        if (error_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ rf_key_replay_window_checker.f @@
rtl/rkrw_pkg.sv
rtl/rkrw_ram.sv
rtl/rkrw_ctrl.sv
rtl/rkrw_dp.sv
rtl/rf_key_replay_window_checker.sv
dv/tb_top.sv
